@@ rtl/pds_pkg.sv @@
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and codes for the periodic deadline scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package pds_pkg;

	localparam int unsigned MAX_CHANNELS_DEF = 16;

	typedef enum logic [1:0] {
		OP_ENABLE  = 2'd0,
		OP_DISABLE = 2'd1,
		OP_TICK    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_STATUS  = 3'd0,
		EV_REGULAR = 3'd1,
		EV_CUSTOM  = 3'd2,
		EV_SERVICE = 3'd3,
		EV_DONE    = 3'd4
	} ev_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} st_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DRD,
		S_DCMP,
		S_SHRD,
		S_SHWR,
		S_TRD,
		S_TCMP,
		S_SVC,
		S_DONE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] period;
		logic [63:0] deadline;
	} entry_t;

	typedef struct packed {
		ev_t         ev;
		st_t         st;
		logic [7:0]  id;
		logic [63:0] dl;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/periodic_deadline_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_deadline_scheduler
// Two compacting timer tables (regular, custom) plus a service channel,
// held in one entry memory and walked by a sequencer.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// in       | in_valid/in_ready  | op kind channel_id period now
// out      | out_valid/out_ready| event_res status fired_id next_deadline last
// cfg      | cfg_wen            | cfg_wdata (service period)
//
// Enable writes the new entry from idle. Disable searches entries, then shifts
// later entries down. Tick scans each table entry, stopping to emit each result,
// then checks the service channel and emits done; the memory's single registered read port sets the pace.
// One item at a time; in_ready is high only when the sequencer is idle.
// Output stall holds the sequencer at its next result. Reset clears counts,
// deadlines and the output valid; table entries need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_deadline_scheduler #(
	parameter int unsigned MAX_CHANNELS = pds_pkg::MAX_CHANNELS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  op,
	input  wire         kind,
	input  wire  [7:0]  channel_id,
	input  wire  [31:0] period,
	input  wire  [63:0] now,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  event_res,
	output logic [1:0]  status,
	output logic [7:0]  fired_id,
	output logic [63:0] next_deadline,
	output logic        last,
	input  wire         cfg_wen,
	input  wire  [31:0] cfg_wdata
);

	localparam int unsigned IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned CW = $clog2(MAX_CHANNELS + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_CHANNELS);

	pds_pkg::state_t state_q, state_d, ret_q, ret_d;
	logic [CW-1:0] cnt_q [0:1];
	logic [CW-1:0] cnt_d [0:1];
	logic [63:0]   glob_q, glob_d, svc_q, svc_d, min_q, min_d, now_q, now_d;
	logic [31:0]   sper_q;
	logic [7:0]    id_q, id_d;
	logic          tbl_q, tbl_d;
	logic [CW-1:0] idx_q, idx_d;
	pds_pkg::res_t res_q, res_d, out_q;
	logic          ov_q, ov_d;

	logic            wen, ren;
	logic [IW:0]     waddr, raddr;
	pds_pkg::entry_t wdata, rdata;
	logic [CW-1:0]   n;
	logic [CW-1:0]   idx1;
	logic [63:0]     nd;

	pds_mem #(.AW(IW + 1)) u_mem (
		.clk   (clk),
		.wen   (wen),
		.waddr (waddr),
		.wdata (wdata),
		.ren   (ren),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pds_pkg::S_IDLE;
			ret_q    <= pds_pkg::S_IDLE;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			glob_q   <= '0;
			svc_q    <= '0;
			sper_q   <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			cnt_q[0] <= cnt_d[0];
			cnt_q[1] <= cnt_d[1];
			glob_q   <= glob_d;
			svc_q    <= svc_d;
			ov_q     <= ov_d;
			if (cfg_wen) begin
				sper_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		min_q <= min_d;
		now_q <= now_d;
		id_q  <= id_d;
		tbl_q <= tbl_d;
		idx_q <= idx_d;
		res_q <= res_d;
		if (ov_d && !(ov_q && !out_ready) && state_q == pds_pkg::S_EMIT) begin
			out_q <= res_q;
		end
	end

	assign n    = cnt_q[tbl_q];
	assign idx1 = idx_q + CW'(1);

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cnt_d[0] = cnt_q[0];
		cnt_d[1] = cnt_q[1];
		glob_d   = glob_q;
		svc_d    = svc_q;
		min_d    = min_q;
		now_d    = now_q;
		id_d     = id_q;
		tbl_d    = tbl_q;
		idx_d    = idx_q;
		res_d    = res_q;
		ov_d     = ov_q && !out_ready;
		in_ready = 1'b0;
		wen      = 1'b0;
		ren      = 1'b0;
		waddr    = {tbl_q, idx_q[IW-1:0]};
		raddr    = {tbl_q, idx_q[IW-1:0]};
		wdata    = rdata;
		nd       = '0;
		unique case (state_q)
			pds_pkg::S_IDLE: begin
				in_ready = 1'b1;
				res_d    = '{ev: pds_pkg::EV_STATUS, st: pds_pkg::ST_OK, id: '0, dl: '0,
				             last: 1'b1};
				now_d    = now;
				id_d     = channel_id;
				tbl_d    = 1'b0;
				idx_d    = '0;
				min_d    = '1;
				ret_d    = pds_pkg::S_IDLE;
				if (in_valid) begin
					unique case (pds_pkg::op_t'(op))
						pds_pkg::OP_ENABLE: begin
							state_d = pds_pkg::S_EMIT;
							if (cnt_q[kind] >= CMAX) begin
								res_d.st = pds_pkg::ST_FULL;
							end else begin
								wen         = 1'b1;
								waddr       = {kind, cnt_q[kind][IW-1:0]};
								wdata       = '{id: channel_id, period: period, deadline: '0};
								cnt_d[kind] = cnt_q[kind] + CW'(1);
							end
						end
						pds_pkg::OP_DISABLE: state_d = pds_pkg::S_DRD;
						pds_pkg::OP_TICK: begin
							if (now < glob_q) begin
								res_d.ev = pds_pkg::EV_DONE;
								res_d.dl = glob_q;
								state_d  = pds_pkg::S_EMIT;
							end else begin
								state_d = pds_pkg::S_TRD;
							end
						end
						default: state_d = pds_pkg::S_IDLE;
					endcase
				end
			end
			pds_pkg::S_DRD: begin
				if (idx_q < n) begin
					ren     = 1'b1;
					state_d = pds_pkg::S_DCMP;
				end else if (!tbl_q) begin
					tbl_d = 1'b1;
					idx_d = '0;
				end else begin
					res_d.st = pds_pkg::ST_NOTFOUND;
					state_d  = pds_pkg::S_EMIT;
				end
			end
			pds_pkg::S_DCMP: begin
				if (rdata.id == id_q) begin
					state_d = pds_pkg::S_SHRD;
				end else begin
					idx_d   = idx1;
					state_d = pds_pkg::S_DRD;
				end
			end
			pds_pkg::S_SHRD: begin
				// pull the next entry down over the removed slot
				if (idx1 < n) begin
					ren     = 1'b1;
					raddr   = {tbl_q, idx1[IW-1:0]};
					state_d = pds_pkg::S_SHWR;
				end else begin
					cnt_d[tbl_q] = n - CW'(1);
					state_d      = pds_pkg::S_EMIT;
				end
			end
			pds_pkg::S_SHWR: begin
				wen     = 1'b1;
				idx_d   = idx1;
				state_d = pds_pkg::S_SHRD;
			end
			pds_pkg::S_TRD: begin
				if (idx_q < n) begin
					ren     = 1'b1;
					state_d = pds_pkg::S_TCMP;
				end else if (!tbl_q) begin
					tbl_d = 1'b1;
					idx_d = '0;
				end else begin
					state_d = pds_pkg::S_SVC;
				end
			end
			pds_pkg::S_TCMP: begin
				idx_d   = idx1;
				state_d = pds_pkg::S_TRD;
				nd      = rdata.deadline;
				if (rdata.deadline <= now_q) begin
					nd             = now_q + {32'd0, rdata.period};
					wen            = 1'b1;
					wdata.deadline = nd;
					res_d          = '{ev: tbl_q ? pds_pkg::EV_CUSTOM : pds_pkg::EV_REGULAR,
					                   st: pds_pkg::ST_OK, id: rdata.id, dl: '0, last: 1'b0};
					ret_d          = pds_pkg::S_TRD;
					state_d        = pds_pkg::S_EMIT;
				end
				if (nd < min_q) begin
					min_d = nd;
				end
			end
			pds_pkg::S_SVC: begin
				nd      = svc_q;
				state_d = pds_pkg::S_DONE;
				if (svc_q <= now_q) begin
					nd      = now_q + {32'd0, sper_q};
					svc_d   = nd;
					res_d   = '{ev: pds_pkg::EV_SERVICE, st: pds_pkg::ST_OK, id: '0, dl: '0,
					            last: 1'b0};
					ret_d   = pds_pkg::S_DONE;
					state_d = pds_pkg::S_EMIT;
				end
				if (nd < min_q) begin
					min_d = nd;
				end
			end
			pds_pkg::S_DONE: begin
				glob_d  = min_q;
				res_d   = '{ev: pds_pkg::EV_DONE, st: pds_pkg::ST_OK, id: '0, dl: min_q,
				            last: 1'b1};
				ret_d   = pds_pkg::S_IDLE;
				state_d = pds_pkg::S_EMIT;
			end
			pds_pkg::S_EMIT: begin
				if (!ov_q || out_ready) begin
					ov_d    = 1'b1;
					state_d = ret_q;
				end
			end
			default: state_d = pds_pkg::S_IDLE;
		endcase
	end

	assign out_valid     = ov_q;
	assign event_res     = out_q.ev;
	assign status        = out_q.st;
	assign fired_id      = out_q.id;
	assign next_deadline = out_q.dl;
	assign last          = out_q.last;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CMAX && cnt_q[1] <= CMAX)
		else $error("table count beyond capacity");

	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pds_pkg::S_EMIT && (!ov_q || out_ready) |=> ov_q)
		else $error("result not loaded into output register");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_q.ev == pds_pkg::EV_DONE |-> out_q.last)
		else $error("tick done without last flag");

	a_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == pds_pkg::S_IDLE && !ren)
		else $error("item taken while sequencer busy");

endmodule
`default_nettype wire

@@ rtl/pds_mem.sv @@
// ----------------------------------------------------------------------------
// pds_mem
// Channel entry memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module pds_mem #(
	parameter int unsigned AW = 5
) (
	input  wire                  clk,
	input  wire                  wen,
	input  wire [AW-1:0]         waddr,
	input  pds_pkg::entry_t      wdata,
	input  wire                  ren,
	input  wire [AW-1:0]         raddr,
	output pds_pkg::entry_t      rdata
);

	pds_pkg::entry_t mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
